// ===== rtl/core/rpc_pkg.sv =====
// Shared widths, reset values, register indexes and types of the range prime counter.
`timescale 1ns / 1ps
package rpc_pkg;

  // Field and register widths
  localparam int unsigned LIMIT_W   = 31;
  localparam int unsigned CHUNK_W   = 21;
  localparam int unsigned COUNT_W   = 20;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 31;

  // Candidate word holds one step past the largest tested value
  localparam int unsigned CAND_W = 32;
  // Dividend width of the remainder unit: tested candidates stay below 2^31
  localparam int unsigned DVD_W  = 31;
  // Trial divisor width: divisors never pass 46342
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned STEP_W = $clog2(DVD_W);

  // Register reset values
  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RST = LIMIT_W'(1000000);
  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST  = CHUNK_W'(500000);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 1'b1;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } rem_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ===== rtl/core/rpc_if.sv =====
// Valid/ready channels for range starts and prime counts.
`timescale 1ns / 1ps
interface rpc_start_if;
  logic                            valid;
  logic                            ready;
  logic [rpc_pkg::LIMIT_W-1:0]     range_start;

  modport source (output valid, output range_start, input ready);
  modport sink   (input valid, input range_start, output ready);
endinterface

interface rpc_count_if;
  logic                            valid;
  logic                            ready;
  logic [rpc_pkg::COUNT_W-1:0]     prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

// ===== rtl/core/range_prime_counter.sv =====
// Work: per odd candidate n up to (floor(sqrt(n))-1)/2 trial divisions in the shared
// bit-serial remainder unit, fewer once a factor is found.
// Throughput: one range at a time; the next start is taken once the count is registered.
// The result waits in an output register, and the next range is accepted meanwhile.
// Reset: asynchronous, active low; upper_limit 1000000, chunk_size 500000, no result held.
`timescale 1ns / 1ps
module range_prime_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rpc_start_if.sink                      in_if,
  rpc_count_if.source                    out_if,
  input  logic                           cfg_we_i,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rpc_pkg::CFG_W-1:0]      cfg_data_i
);

  logic [rpc_pkg::LIMIT_W-1:0] upper_limit_q;
  logic [rpc_pkg::CHUNK_W-1:0] chunk_size_q;
  rpc_pkg::rem_req_t           rem_req;
  rpc_pkg::rem_rsp_t           rem_rsp;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_limit_q <= rpc_pkg::UPPER_LIMIT_RST;
      chunk_size_q  <= rpc_pkg::CHUNK_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpc_pkg::REG_UPPER_LIMIT: upper_limit_q <= cfg_data_i[rpc_pkg::LIMIT_W-1:0];
        rpc_pkg::REG_CHUNK_SIZE:  chunk_size_q  <= cfg_data_i[rpc_pkg::CHUNK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpc_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .out_if        (out_if),
    .upper_limit_i (upper_limit_q),
    .chunk_size_i  (chunk_size_q),
    .rem_req_o     (rem_req),
    .rem_rsp_i     (rem_rsp)
  );

  rpc_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

endmodule

// ===== rtl/core/rpc_rem_unit.sv =====
// Bit-serial restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module rpc_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpc_pkg::rem_req_t req_i,
  output rpc_pkg::rem_rsp_t rsp_o
);

  localparam logic [rpc_pkg::STEP_W-1:0] LastStep = rpc_pkg::STEP_W'(rpc_pkg::DVD_W - 1);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [rpc_pkg::STEP_W-1:0]   step_q, step_d;
  logic [rpc_pkg::DVD_W-1:0]    dvd_q, dvd_d;
  logic [rpc_pkg::DIV_W-1:0]    rem_q, rem_d;
  logic [rpc_pkg::DIV_W-1:0]    dsr_q, dsr_d;
  logic [rpc_pkg::DIV_W:0]      trial;
  logic [rpc_pkg::DIV_W:0]      diff;

  // Shift in the next dividend bit and subtract where it fits
  assign trial = {rem_q, dvd_q[rpc_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[rpc_pkg::DVD_W-2:0], 1'b0};
      rem_d  = (trial >= {1'b0, dsr_q}) ? diff[rpc_pkg::DIV_W-1:0]
                                        : trial[rpc_pkg::DIV_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("remainder done without a run");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= LastStep)
    else $error("remainder step counter past last step");
`endif

endmodule

// ===== rtl/core/rpc_seq.sv =====
// Sequencer: walks candidates and trial divisors, counts primes, holds the result.
`timescale 1ns / 1ps
module rpc_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rpc_start_if.sink                    in_if,
  rpc_count_if.source                  out_if,
  input  logic [rpc_pkg::LIMIT_W-1:0]  upper_limit_i,
  input  logic [rpc_pkg::CHUNK_W-1:0]  chunk_size_i,
  output rpc_pkg::rem_req_t            rem_req_o,
  input  rpc_pkg::rem_rsp_t            rem_rsp_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_CAND   = 3'd2;
  localparam logic [2:0] ST_TEST   = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam int unsigned CW = rpc_pkg::CAND_W;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                cand_q, cand_d;
  logic [CW-1:0]                end_q, end_d;
  logic [rpc_pkg::DIV_W-1:0]    div_q, div_d;
  logic [CW-1:0]                sq_q, sq_d;
  logic [rpc_pkg::COUNT_W-1:0]  count_q, count_d;
  logic                         out_valid_q, out_valid_d;
  logic [rpc_pkg::COUNT_W-1:0]  out_count_q, out_count_d;

  always_comb begin
    logic [CW-1:0] sum;
    logic [CW-1:0] limit;
    logic          hit;
    logic          adv;

    state_d     = state_q;
    cand_d      = cand_q;
    end_d       = end_q;
    div_d       = div_q;
    sq_d        = sq_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    hit         = 1'b0;
    adv         = 1'b0;
    sum         = cand_q + CW'(chunk_size_i);
    limit       = CW'(upper_limit_i);

    rem_req_o.start    = 1'b0;
    rem_req_o.dividend = cand_q[rpc_pkg::DVD_W-1:0];
    rem_req_o.divisor  = div_q;

    // Drop the result once it has been taken
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          cand_d  = CW'(in_if.range_start);
          count_d = '0;
          state_d = ST_SETUP;
        end
      end
      // Bound the range by the chunk and the upper limit
      ST_SETUP: begin
        end_d   = (sum > limit) ? limit : sum;
        state_d = ST_CAND;
      end
      ST_CAND: begin
        if (cand_q >= end_q) begin
          state_d = ST_FINISH;
        end else if (cand_q < CW'(2)) begin
          adv = 1'b1;
        end else if (cand_q < CW'(4)) begin
          hit = 1'b1;
          adv = 1'b1;
        end else if (!cand_q[0]) begin
          adv = 1'b1;
        end else begin
          div_d   = rpc_pkg::DIV_W'(3);
          sq_d    = CW'(9);
          state_d = ST_TEST;
        end
      end
      // Prime once the divisor square passes the candidate
      ST_TEST: begin
        if (sq_q > cand_q) begin
          hit = 1'b1;
          adv = 1'b1;
        end else begin
          rem_req_o.start = 1'b1;
          state_d         = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_rsp_i.done) begin
          if (rem_rsp_i.zero) begin
            adv = 1'b1;
          end else begin
            div_d   = div_q + rpc_pkg::DIV_W'(2);
            sq_d    = sq_q + CW'({div_q, 2'b00}) + CW'(4);
            state_d = ST_TEST;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_count_d = count_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Count with saturation and step the candidate on by two
    if (hit && (count_q != rpc_pkg::COUNT_MAX)) begin
      count_d = count_q + 1'b1;
    end
    if (adv) begin
      cand_d  = cand_q + CW'(2);
      state_d = ST_CAND;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    end_q       <= end_d;
    div_q       <= div_d;
    sq_q        <= sq_d;
    count_q     <= count_d;
    out_count_q <= out_count_d;
  end

  assign in_if.ready        = (state_q == ST_IDLE);
  assign out_if.valid       = out_valid_q;
  assign out_if.prime_count = out_count_q;

`ifndef SYNTH
  a_div_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_req_o.start |-> div_q[0] && (div_q >= rpc_pkg::DIV_W'(3)) && (sq_q <= cand_q))
    else $error("trial division issued with a bad divisor");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish");

  a_idle_unit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !rem_rsp_i.busy)
    else $error("remainder unit busy while sequencer idle");
`endif

endmodule
